@@ design/mpsm_pkg.sv @@
`timescale 1ns / 1ps

package mpsm_pkg;

	localparam int NODES_DEF    = 256;
	localparam int PATTERNS_DEF = 32;
	localparam int POS_BITS_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int OPOS_W  = 32;
	localparam int OIDX_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PAT_BYTE = 3'd0,
		CMD_PAT_END  = 3'd1,
		CMD_BUILD    = 3'd2,
		CMD_TEXT     = 3'd3,
		CMD_NEW_TEXT = 3'd4
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MATCH = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_BAD   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OPOS_W-1:0] start_pos;
		logic [OPOS_W-1:0] end_pos;
		logic [OIDX_W-1:0] pat_id;
		logic              last;
	} result_t;

endpackage

@@ design/mpsm_req_if.sv @@
`timescale 1ns / 1ps

interface mpsm_req_if;
	logic                         valid;
	logic                         ready;
	logic [mpsm_pkg::CMD_W-1:0]   cmd;
	logic [mpsm_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

@@ design/mpsm_res_if.sv @@
`timescale 1ns / 1ps

interface mpsm_res_if;
	logic                         valid;
	logic                         ready;
	logic [mpsm_pkg::KIND_W-1:0]  kind;
	logic [mpsm_pkg::OPOS_W-1:0]  start_pos;
	logic [mpsm_pkg::OPOS_W-1:0]  end_pos;
	logic [mpsm_pkg::OIDX_W-1:0]  pat_id;
	logic                         last;

	modport source (output valid, output kind, output start_pos, output end_pos,
		output pat_id, output last, input ready);
	modport sink (input valid, input kind, input start_pos, input end_pos,
		input pat_id, input last, output ready);
endinterface

@@ design/multi_pattern_string_matcher.sv @@
`timescale 1ns / 1ps

// Aho-Corasick matcher over a trie of up to NODES nodes and PATTERNS patterns,
// driven by one small sequencer around six single-port-read RAMs. After reset
// the child table and pattern-list heads are swept clear, during which no
// request is taken. A request is taken only while the sequencer is idle.
// New text and unused commands leave the sequencer idle; every other request
// keeps it busy: a pattern byte reads and may write one child slot, end
// pattern walks the patterns already ending at that node, build visits every
// child slot of each node and takes failure steps, and a text byte follows
// failure steps, failure links along the output chain and each match.
// Results leave through a pending and an output register, so a stalled sink
// holds the sequencer only when a further result is ready.
module multi_pattern_string_matcher #(
	parameter int NODES    = mpsm_pkg::NODES_DEF,
	parameter int PATTERNS = mpsm_pkg::PATTERNS_DEF,
	parameter int POS_BITS = mpsm_pkg::POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mpsm_req_if.sink    req,
	mpsm_res_if.source  res
);
	localparam int NW    = $clog2(NODES);
	localparam int NC_W  = $clog2(NODES + 1);
	localparam int PC_W  = $clog2(PATTERNS + 1);
	localparam int PI_W  = PATTERNS > 1 ? $clog2(PATTERNS) : 1;
	localparam int CA_W  = NW + 8;
	localparam int LEN_W = NW;
	localparam logic [PC_W-1:0] PNONE = PC_W'(PATTERNS);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_ERR, ST_PB, ST_EP, ST_EPW,
		ST_BCH, ST_BFC, ST_BFF, ST_BN, ST_BDQ, ST_BFL,
		ST_TCH, ST_TFL, ST_TFP, ST_TM, ST_TNX, ST_TNF, ST_TEND
	} state_t;

	state_t                  state_q;
	logic [CA_W-1:0]         clr_q;
	logic [NW-1:0]           cursor_q, cur_q, bn_q, fbase_q, f_q, ch_q, n_q;
	logic [NC_W-1:0]         node_cnt_q, head_q, tail_q;
	logic [PC_W-1:0]         pc_q, p_q;
	logic [LEN_W-1:0]        len_q;
	logic                    built_q, root_q, out_v_q, pend_v_q;
	logic [POS_BITS-1:0]     pos_q;
	logic [7:0]              byte_q, c_q, c_nxt;
	logic [mpsm_pkg::KIND_W-1:0] err_q;
	mpsm_pkg::result_t       out_q, pend_q, mres, out_nxt;

	logic                    ch_we, fl_we, fp_we, nx_we, ln_we, q_we;
	logic [CA_W-1:0]         ch_wa, ch_ra;
	logic [NW-1:0]           ch_wd, ch_rd;
	logic [NW-1:0]           fl_wa, fl_ra, fl_wd, fl_rd;
	logic [NW-1:0]           fp_wa, fp_ra;
	logic [PC_W-1:0]         fp_wd, fp_rd;
	logic [PI_W-1:0]         nx_wa, nx_ra, ln_wa, ln_ra;
	logic [PC_W-1:0]         nx_wd, nx_rd;
	logic [LEN_W-1:0]        ln_wd, ln_rd;
	logic [NW-1:0]           q_wa, q_ra, q_wd, q_rd;

	logic                    acc, out_free, tm_go, out_load;
	logic [POS_BITS-1:0]     start_p;
	logic [POS_BITS+31:0]    s_ext, e_ext;
	logic [PC_W+4:0]         pidx_ext;

	assign acc      = req.valid && req.ready;
	assign out_free = !out_v_q || res.ready;
	assign tm_go    = !pend_v_q || out_free;
	assign c_nxt    = c_q + 8'd1;
	assign start_p  = pos_q - POS_BITS'(ln_rd) + POS_BITS'(1);
	assign s_ext    = {32'd0, start_p};
	assign e_ext    = {32'd0, pos_q};
	assign pidx_ext = {5'd0, p_q};

	always_comb begin
		mres.kind      = mpsm_pkg::KIND_MATCH;
		mres.start_pos = s_ext[31:0];
		mres.end_pos   = e_ext[31:0];
		mres.pat_id    = pidx_ext[4:0];
		mres.last      = 1'b0;
	end

	always_comb begin
		out_load = 1'b0;
		out_nxt  = pend_q;
		unique case (state_q)
			ST_ERR: begin
				out_load     = out_free;
				out_nxt      = '0;
				out_nxt.kind = err_q;
				out_nxt.last = 1'b1;
			end
			ST_TM:   out_load = tm_go && pend_v_q;
			ST_TEND: begin
				out_load     = pend_v_q && out_free;
				out_nxt.last = 1'b1;
			end
			default: ;
		endcase
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign res.valid     = out_v_q;
	assign res.kind      = out_q.kind;
	assign res.start_pos = out_q.start_pos;
	assign res.end_pos   = out_q.end_pos;
	assign res.pat_id    = out_q.pat_id;
	assign res.last      = out_q.last;

	mpsm_ram #(.WIDTH(NW), .DEPTH(NODES * 256)) u_child (
		.clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));
	mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
		.clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
	mpsm_ram #(.WIDTH(PC_W), .DEPTH(NODES)) u_first (
		.clk(clk), .we(fp_we), .waddr(fp_wa), .wdata(fp_wd), .raddr(fp_ra), .rdata(fp_rd));
	mpsm_ram #(.WIDTH(PC_W), .DEPTH(PATTERNS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
	mpsm_ram #(.WIDTH(LEN_W), .DEPTH(PATTERNS)) u_len (
		.clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
	mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

	always_comb begin
		ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
		fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
		fp_we = 1'b0; fp_wa = '0; fp_wd = '0; fp_ra = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
		ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
		q_we  = 1'b0; q_wa  = '0; q_wd  = '0; q_ra  = '0;
		unique case (state_q)
			ST_CLR: begin
				ch_we = 1'b1;
				ch_wa = clr_q;
				fp_we = (clr_q < CA_W'(NODES));
				fp_wa = clr_q[NW-1:0];
				fp_wd = PNONE;
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (mpsm_pkg::cmd_t'(req.cmd))
						mpsm_pkg::CMD_PAT_BYTE: ch_ra = {cursor_q, req.data_byte};
						mpsm_pkg::CMD_PAT_END: begin
							if (pc_q != PNONE && cursor_q != '0) begin
								nx_we = 1'b1;
								nx_wa = pc_q[PI_W-1:0];
								nx_wd = PNONE;
								ln_we = 1'b1;
								ln_wa = pc_q[PI_W-1:0];
								ln_wd = len_q;
								fp_ra = cursor_q;
							end
						end
						mpsm_pkg::CMD_BUILD: begin
							fl_we = 1'b1;
							ch_ra = '0;
						end
						mpsm_pkg::CMD_TEXT: ch_ra = {cur_q, req.data_byte};
						default: ;
					endcase
				end
			end
			ST_PB: begin
				if (ch_rd == '0 && node_cnt_q != NC_W'(NODES)) begin
					ch_we = 1'b1;
					ch_wa = {cursor_q, byte_q};
					ch_wd = node_cnt_q[NW-1:0];
				end
			end
			ST_EP: begin
				if (fp_rd == PNONE) begin
					fp_we = 1'b1;
					fp_wa = cursor_q;
					fp_wd = pc_q;
				end else begin
					nx_ra = fp_rd[PI_W-1:0];
				end
			end
			ST_EPW: begin
				if (nx_rd != PNONE) begin
					nx_ra = nx_rd[PI_W-1:0];
				end else begin
					nx_we = 1'b1;
					nx_wa = p_q[PI_W-1:0];
					nx_wd = pc_q;
				end
			end
			ST_BCH: begin
				if (ch_rd != '0 && !root_q) begin
					ch_ra = {fbase_q, c_q};
				end else begin
					if (ch_rd != '0) begin
						fl_we = 1'b1;
						fl_wa = ch_rd;
						q_we  = 1'b1;
						q_wa  = tail_q[NW-1:0];
						q_wd  = ch_rd;
					end
					ch_ra = {bn_q, c_nxt};
				end
			end
			ST_BFC: begin
				if (ch_rd != '0 || f_q == '0) begin
					fl_we = 1'b1;
					fl_wa = ch_q;
					fl_wd = ch_rd;
					q_we  = 1'b1;
					q_wa  = tail_q[NW-1:0];
					q_wd  = ch_q;
					ch_ra = {bn_q, c_nxt};
				end else begin
					fl_ra = f_q;
				end
			end
			ST_BFF:  ch_ra = {fl_rd, c_q};
			ST_BN:   q_ra  = head_q[NW-1:0];
			ST_BDQ:  fl_ra = q_rd;
			ST_BFL:  ch_ra = {bn_q, 8'd0};
			ST_TCH: begin
				if (cur_q != '0 && ch_rd == '0) begin
					fl_ra = cur_q;
				end else begin
					fp_ra = ch_rd;
				end
			end
			ST_TFL:  ch_ra = {fl_rd, byte_q};
			ST_TFP: begin
				ln_ra = fp_rd[PI_W-1:0];
				nx_ra = fp_rd[PI_W-1:0];
			end
			ST_TM: begin
				ln_ra = tm_go ? nx_rd[PI_W-1:0] : p_q[PI_W-1:0];
				nx_ra = tm_go ? nx_rd[PI_W-1:0] : p_q[PI_W-1:0];
			end
			ST_TNX:  fl_ra = n_q;
			ST_TNF:  fp_ra = fl_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			cursor_q   <= '0;
			cur_q      <= '0;
			bn_q       <= '0;
			fbase_q    <= '0;
			f_q        <= '0;
			ch_q       <= '0;
			n_q        <= '0;
			node_cnt_q <= NC_W'(1);
			head_q     <= '0;
			tail_q     <= '0;
			pc_q       <= '0;
			p_q        <= '0;
			len_q      <= '0;
			built_q    <= 1'b0;
			root_q     <= 1'b0;
			out_v_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			pos_q      <= '0;
			byte_q     <= '0;
			c_q        <= '0;
			err_q      <= '0;
			out_q      <= '0;
			pend_q     <= '0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
				out_q   <= out_nxt;
			end else if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CA_W'(1);
					if (clr_q == CA_W'(NODES * 256 - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						byte_q <= req.data_byte;
						unique case (mpsm_pkg::cmd_t'(req.cmd))
							mpsm_pkg::CMD_PAT_BYTE: begin
								if (pc_q == PNONE) begin
									err_q   <= mpsm_pkg::KIND_FULL;
									state_q <= ST_ERR;
								end else begin
									state_q <= ST_PB;
								end
							end
							mpsm_pkg::CMD_PAT_END: begin
								if (pc_q == PNONE) begin
									err_q   <= mpsm_pkg::KIND_FULL;
									state_q <= ST_ERR;
								end else if (cursor_q == '0) begin
									err_q   <= mpsm_pkg::KIND_BAD;
									state_q <= ST_ERR;
								end else begin
									state_q <= ST_EP;
								end
							end
							mpsm_pkg::CMD_BUILD: begin
								head_q  <= '0;
								tail_q  <= '0;
								bn_q    <= '0;
								c_q     <= '0;
								root_q  <= 1'b1;
								state_q <= ST_BCH;
							end
							mpsm_pkg::CMD_TEXT: begin
								if (!built_q) begin
									err_q   <= mpsm_pkg::KIND_BAD;
									state_q <= ST_ERR;
								end else begin
									state_q <= ST_TCH;
								end
							end
							mpsm_pkg::CMD_NEW_TEXT: begin
								cur_q <= '0;
								pos_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PB: begin
					if (ch_rd != '0) begin
						cursor_q <= ch_rd;
						len_q    <= len_q + LEN_W'(1);
						built_q  <= 1'b0;
						state_q  <= ST_IDLE;
					end else if (node_cnt_q == NC_W'(NODES)) begin
						err_q   <= mpsm_pkg::KIND_FULL;
						state_q <= ST_ERR;
					end else begin
						cursor_q   <= node_cnt_q[NW-1:0];
						node_cnt_q <= node_cnt_q + NC_W'(1);
						len_q      <= len_q + LEN_W'(1);
						built_q    <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_EP, ST_EPW: begin
					if ((state_q == ST_EP && fp_rd == PNONE) ||
						(state_q == ST_EPW && nx_rd == PNONE)) begin
						pc_q     <= pc_q + PC_W'(1);
						len_q    <= '0;
						cursor_q <= '0;
						built_q  <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						p_q     <= (state_q == ST_EP) ? fp_rd : nx_rd;
						state_q <= ST_EPW;
					end
				end
				ST_BCH: begin
					if (ch_rd != '0 && !root_q) begin
						ch_q    <= ch_rd;
						f_q     <= fbase_q;
						state_q <= ST_BFC;
					end else begin
						if (ch_rd != '0) begin
							tail_q <= tail_q + NC_W'(1);
						end
						if (c_q == 8'hFF) begin
							state_q <= ST_BN;
						end else begin
							c_q     <= c_nxt;
							state_q <= ST_BCH;
						end
					end
				end
				ST_BFC: begin
					if (ch_rd != '0 || f_q == '0) begin
						tail_q <= tail_q + NC_W'(1);
						if (c_q == 8'hFF) begin
							state_q <= ST_BN;
						end else begin
							c_q     <= c_nxt;
							state_q <= ST_BCH;
						end
					end else begin
						state_q <= ST_BFF;
					end
				end
				ST_BFF: begin
					f_q     <= fl_rd;
					state_q <= ST_BFC;
				end
				ST_BN: begin
					root_q <= 1'b0;
					if (head_q == tail_q) begin
						built_q <= 1'b1;
						cur_q   <= '0;
						pos_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_BDQ;
					end
				end
				ST_BDQ: begin
					bn_q    <= q_rd;
					head_q  <= head_q + NC_W'(1);
					state_q <= ST_BFL;
				end
				ST_BFL: begin
					fbase_q <= fl_rd;
					c_q     <= '0;
					state_q <= ST_BCH;
				end
				ST_TCH: begin
					if (cur_q != '0 && ch_rd == '0) begin
						state_q <= ST_TFL;
					end else begin
						cur_q   <= ch_rd;
						n_q     <= ch_rd;
						state_q <= ST_TFP;
					end
				end
				ST_TFL: begin
					cur_q   <= fl_rd;
					state_q <= ST_TCH;
				end
				ST_TFP: begin
					if (fp_rd != PNONE) begin
						p_q     <= fp_rd;
						state_q <= ST_TM;
					end else begin
						state_q <= ST_TNX;
					end
				end
				ST_TM: begin
					if (tm_go) begin
						pend_q   <= mres;
						pend_v_q <= 1'b1;
						p_q      <= nx_rd;
						if (nx_rd == PNONE) begin
							state_q <= ST_TNX;
						end
					end
				end
				ST_TNX: begin
					state_q <= (n_q == '0) ? ST_TEND : ST_TNF;
				end
				ST_TNF: begin
					n_q     <= fl_rd;
					state_q <= ST_TFP;
				end
				ST_TEND: begin
					if (!pend_v_q) begin
						pos_q   <= pos_q + POS_BITS'(1);
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						pos_q    <= pos_q + POS_BITS'(1);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ design/mpsm_ram.sv @@
`timescale 1ns / 1ps

module mpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ design/mpsm_checker.sv @@
`timescale 1ns / 1ps

module mpsm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [mpsm_pkg::CMD_W-1:0]  req_cmd,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [mpsm_pkg::KIND_W-1:0] res_kind,
	input logic [mpsm_pkg::OPOS_W-1:0] res_start_pos,
	input logic [mpsm_pkg::OPOS_W-1:0] res_end_pos,
	input logic [mpsm_pkg::OIDX_W-1:0] res_pat_id,
	input logic                        res_last
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
		$stable(res_start_pos) && $stable(res_end_pos) &&
		$stable(res_pat_id) && $stable(res_last))
		else $error("result changed while stalled");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != mpsm_pkg::KIND_MATCH |-> res_last &&
		res_start_pos == '0 && res_end_pos == '0 && res_pat_id == '0)
		else $error("error result with payload");

	a_only_match_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> res_kind == mpsm_pkg::KIND_MATCH)
		else $error("non-final result is not a match");

	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd == mpsm_pkg::CMD_TEXT |=> !req_ready)
		else $error("ready right after text byte");
endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_cmd(req.cmd),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_kind(res.kind),
	.res_start_pos(res.start_pos),
	.res_end_pos(res.end_pos),
	.res_pat_id(res.pat_id),
	.res_last(res.last)
);
